// ----- sv/jbf_pkg.sv -----
// Shared types and constants for the joint bilateral filter unit.
package jbf_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_RADIUS   = 20;
    localparam int COLOUR_DEPTH = 768;
    localparam int DIST_DEPTH   = 2 * MAX_RADIUS * MAX_RADIUS + 1;
    localparam int PIX_AW       = 16;
    localparam int TBL_AW       = 10;
    localparam int NUM_W        = 52;
    localparam int DEN_W        = 28;

    localparam logic [1:0] MODE_PIXEL  = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_COLOUR = 2'd2;
    localparam logic [1:0] MODE_DIST   = 2'd3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [23:0] colour;
        logic [23:0] signal;
    } pixel_t;

    typedef struct packed {
        logic        colour_we;
        logic        dist_we;
        logic [9:0]  index;
        logic [15:0] weight;
    } tbl_wr_t;

endpackage

// ----- sv/jbf_pixel_store.sv -----
// Guide colour and signal frame memory, one port, registered read.
module jbf_pixel_store
    import jbf_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [PIX_AW-1:0] addr,
    input  pixel_t            wdata,
    output pixel_t            rdata
);

    pixel_t mem [0:MAX_WIDTH*MAX_HEIGHT-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- sv/jbf_weight_tables.sv -----
// Colour and distance weight tables, registered reads.
module jbf_weight_tables
    import jbf_pkg::*;
(
    input  logic              clk,
    input  tbl_wr_t           wr,
    input  logic [TBL_AW-1:0] colour_addr,
    input  logic [TBL_AW-1:0] dist_addr,
    output logic [15:0]       colour_weight,
    output logic [15:0]       dist_weight
);

    logic [15:0] colour_mem [0:COLOUR_DEPTH-1];
    logic [15:0] dist_mem   [0:DIST_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr.colour_we)
        begin
            if (wr.index < TBL_AW'(COLOUR_DEPTH))
            begin
                colour_mem[wr.index] <= wr.weight;
            end
        end
        else
        begin
            colour_weight <= colour_mem[colour_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.dist_we)
        begin
            if (wr.index < TBL_AW'(DIST_DEPTH))
            begin
                dist_mem[wr.index] <= wr.weight;
            end
        end
        else
        begin
            dist_weight <= dist_mem[dist_addr];
        end
    end

endmodule

// ----- sv/jbf_divider.sv -----
// Bit-serial restoring divider, signed numerator, truncates toward zero.
module jbf_divider
    import jbf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic [23:0]             quotient
);

    logic [NUM_W-2:0] dividend_reg;
    logic [NUM_W-2:0] quo_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             neg_reg;
    logic             done_reg;
    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign rem_sh = {rem_reg[DEN_W-1:0], dividend_reg[NUM_W-2]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(NUM_W - 2))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= mag[NUM_W-2:0];
            den_reg      <= den;
            neg_reg      <= num[NUM_W-1];
            rem_reg      <= '0;
            quo_reg      <= '0;
        end
        else if (busy_reg)
        begin
            dividend_reg <= {dividend_reg[NUM_W-3:0], 1'b0};
            rem_reg      <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            quo_reg      <= {quo_reg[NUM_W-3:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 24'(-quo_reg[23:0]) : quo_reg[23:0];

endmodule

// ----- sv/joint_bilateral_filter_unit.sv -----
// Joint bilateral filter: sequencer, weight/MAC pipeline and result register.
// A query raises its result after one centre read, one neighbour per cycle, the
// weight/multiply pipeline drain, the bit-serial divider and a load of the result
// register. Items are taken one at a time; a held result stalls it.
// Reset (async, active low) clears control state and sets width 256,
// height 256, radius 1; the memories are not cleared.
module joint_bilateral_filter_unit
    import jbf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x, pos_y, red, green, blue, signal_value, table_index, table_weight
    input  logic [95:0] s_tdata,
    // mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // filtered_value, out_x, out_y
    output logic [39:0] m_tdata
);

    state_t state_reg, state_next;

    logic [8:0] width_reg, height_reg;
    logic [4:0] radius_reg;
    logic [8:0] eff_w, eff_h;
    logic [4:0] eff_r;

    logic [7:0]  in_x, in_y;
    logic [1:0]  in_mode;
    logic        accept, query_ok, last_pos, pipe_empty, div_start, div_done;
    logic [7:0]  px_reg, py_reg;
    logic [23:0] cc_reg;
    logic signed [5:0] dx_reg, dy_reg;
    logic signed [9:0] nx, ny;
    logic        nb_valid;
    logic [4:0]  adx, ady;
    logic [9:0]  win_dist;

    logic [PIX_AW-1:0] pix_addr;
    logic              pix_we;
    pixel_t            pix_wdata, pix_rdata;
    tbl_wr_t           tbl_wr;
    logic [15:0]       cw, dw;
    logic [9:0]        diff;
    logic [23:0]       quotient;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [9:0]        dist1_reg;
    logic signed [23:0] sig2_reg, sig3_reg;
    logic [15:0]       wgt3_reg, wgt4_reg;
    logic signed [40:0] prod4_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              m_valid_reg;
    logic [39:0]       m_data_reg;
    logic [31:0]       wprod;

    assign in_mode = s_tuser;
    assign in_x    = s_tdata[7:0];
    assign in_y    = s_tdata[15:8];

    assign eff_w = (width_reg == 9'd0) ? 9'd1 :
                   (width_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_reg;
    assign eff_h = (height_reg == 9'd0) ? 9'd1 :
                   (height_reg > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_reg;
    assign eff_r = (radius_reg == 5'd0) ? 5'd1 :
                   (radius_reg > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : radius_reg;

    assign accept   = s_tvalid && s_tready;
    assign query_ok = ({1'b0, in_x} < eff_w) && ({1'b0, in_y} < eff_h);
    assign last_pos = (dx_reg == $signed({1'b0, eff_r})) &&
                      (dy_reg == $signed({1'b0, eff_r}));
    assign pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);

    // neighbour position and window distance
    assign nx  = $signed({2'b00, px_reg}) + 10'(dx_reg);
    assign ny  = $signed({2'b00, py_reg}) + 10'(dy_reg);
    assign nb_valid = !(dx_reg == 6'sd0 && dy_reg == 6'sd0) &&
                      (nx >= 10'sd0) && (nx < $signed({1'b0, eff_w})) &&
                      (ny >= 10'sd0) && (ny < $signed({1'b0, eff_h}));
    assign adx  = dx_reg[5] ? 5'(-dx_reg) : dx_reg[4:0];
    assign ady  = dy_reg[5] ? 5'(-dy_reg) : dy_reg[4:0];
    assign win_dist = 10'(adx) * 10'(adx) + 10'(ady) * 10'(ady);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_mode == MODE_QUERY && query_ok)
                begin
                    state_next = ST_CENTRE;
                end
            end
            ST_CENTRE: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (last_pos)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        pix_we    = 1'b0;
        pix_addr  = {in_y, in_x};
        tbl_wr    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                pix_we        = accept && in_mode == MODE_PIXEL;
                tbl_wr.colour_we = accept && in_mode == MODE_COLOUR;
                tbl_wr.dist_we   = accept && in_mode == MODE_DIST;
            end
            ST_SCAN:   pix_addr  = {ny[7:0], nx[7:0]};
            ST_DRAIN:  div_start = pipe_empty;
            default:   pix_addr  = {in_y, in_x};
        endcase
        tbl_wr.index  = s_tdata[73:64];
        tbl_wr.weight = s_tdata[89:74];
    end

    assign pix_wdata.colour = s_tdata[39:16];
    assign pix_wdata.signal = s_tdata[63:40];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            width_reg   <= 9'(MAX_WIDTH);
            height_reg  <= 9'(MAX_HEIGHT);
            radius_reg  <= 5'd1;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_WIDTH:  width_reg  <= cfg_wdata;
                    REG_HEIGHT: height_reg <= cfg_wdata;
                    REG_RADIUS: radius_reg <= cfg_wdata[4:0];
                    default:    ;
                endcase
            end
            v1_reg <= (state_reg == ST_SCAN) && nb_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // colour distance of the neighbour just read
    always_comb
    begin
        logic [7:0] dr, dg, db;
        dr = (cc_reg[23:16] > pix_rdata.colour[23:16]) ?
             cc_reg[23:16] - pix_rdata.colour[23:16] :
             pix_rdata.colour[23:16] - cc_reg[23:16];
        dg = (cc_reg[15:8] > pix_rdata.colour[15:8]) ?
             cc_reg[15:8] - pix_rdata.colour[15:8] :
             pix_rdata.colour[15:8] - cc_reg[15:8];
        db = (cc_reg[7:0] > pix_rdata.colour[7:0]) ?
             cc_reg[7:0] - pix_rdata.colour[7:0] :
             pix_rdata.colour[7:0] - cc_reg[7:0];
        diff = 10'(dr) + 10'(dg) + 10'(db);
    end

    assign wprod = cw * dw;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (state_reg == ST_CENTRE)
        begin
            cc_reg  <= pix_rdata.colour;
            num_reg <= NUM_W'($signed(pix_rdata.signal)) <<< 16;
            den_reg <= DEN_W'(32'h0001_0000);
            dx_reg  <= -$signed({1'b0, eff_r});
            dy_reg  <= -$signed({1'b0, eff_r});
        end
        else
        begin
            if (state_reg == ST_SCAN)
            begin
                if (dx_reg == $signed({1'b0, eff_r}))
                begin
                    dx_reg <= -$signed({1'b0, eff_r});
                    dy_reg <= dy_reg + 6'sd1;
                end
                else
                begin
                    dx_reg <= dx_reg + 6'sd1;
                end
            end
            if (v4_reg)
            begin
                num_reg <= num_reg + NUM_W'(prod4_reg);
                den_reg <= den_reg + DEN_W'(wgt4_reg);
            end
        end
        dist1_reg <= win_dist;
        sig2_reg  <= pix_rdata.signal;
        sig3_reg  <= sig2_reg;
        wgt3_reg  <= wprod[31:16];
        wgt4_reg  <= wgt3_reg;
        prod4_reg <= $signed({1'b0, wgt3_reg}) * sig3_reg;
        // load only once the previous result has left
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
        begin
            m_data_reg <= {py_reg, px_reg, quotient};
        end
    end

    jbf_pixel_store u_pixels (
        .clk   (clk),
        .we    (pix_we),
        .addr  (pix_addr),
        .wdata (pix_wdata),
        .rdata (pix_rdata)
    );

    jbf_weight_tables u_tables (
        .clk           (clk),
        .wr            (tbl_wr),
        .colour_addr   (diff),
        .dist_addr     (dist1_reg),
        .colour_weight (cw),
        .dist_weight   (dw)
    );

    jbf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_reg),
        .den      (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(v1_reg || v2_reg || v3_reg || v4_reg))
        else $error("weight pipeline busy while idle");

    a_div_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !(v1_reg || v2_reg || v3_reg || v4_reg))
        else $error("divider started before accumulation finished");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");
`endif

endmodule
